@@ rtl/crr_pkg.sv @@
// Shared constants and types for the cascaded range remap unit.
// No dependencies.
`timescale 1ns / 1ps

package crr_pkg;

    localparam int STAGES  = 8;
    localparam int ENTRIES = 32;
    localparam int TOTAL   = STAGES * ENTRIES;

    localparam int DATA_W   = 64;
    localparam int OP_W     = 2;
    localparam int STAGE_W  = 3;
    localparam int SLOT_W   = 5;
    localparam int CFG_W    = 4;
    localparam int HITS_W   = 4;
    localparam int ADDR_W   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int ENTRY_W  = 3 * DATA_W;
    localparam int SCNT_W   = $clog2(ENTRIES + 3);
    localparam int STCNT_W  = $clog2(STAGES + 1);

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_TRANSLATE = 2'd0,
        OP_WRITE     = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

endpackage

@@ rtl/crr_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module crr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cascaded_range_remap_unit.sv @@
// Cascaded range remap unit: top level with the entry RAM and the scan sequencer.
// Depends on crr_pkg and crr_ram.
`timescale 1ns / 1ps
// Write and clear items are handled while the block stays idle. A translate item
// scans each stage in use (the configured count, capped at STAGES) entry by entry
// through the read and candidate registers; its result then waits in S_DONE until
// the output register is free, and only then is the next item taken. The single
// read port of the entry RAM, read one entry per cycle, sets the scan speed. One
// item is worked on at a time. Reset clears all valid bits at once and sets r_cfg
// to 8; entry contents are undefined until written.

module cascaded_range_remap_unit
    import crr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [STAGE_W-1:0]  i_stage,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [DATA_W-1:0]   i_dst_start,
    input  logic [DATA_W-1:0]   i_src_start,
    input  logic [DATA_W-1:0]   i_length,
    input  logic [DATA_W-1:0]   i_value,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [DATA_W-1:0]   o_mapped_value,
    output logic [HITS_W-1:0]   o_stages_hit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [TOTAL-1:0]     r_entry_valid;

    // Scan position: a running RAM address, the slot phase within the current
    // stage, and the number of stages already applied.
    logic [ADDR_W-1:0]    r_addr;
    logic [SCNT_W-1:0]    r_slot;
    logic [STCNT_W-1:0]   r_stage_cnt;
    logic [STCNT_W-1:0]   r_n;
    logic [DATA_W-1:0]    r_value;
    logic [HITS_W-1:0]    r_hits;

    // Read pipeline: a read issued last cycle and that entry's valid bit.
    logic                 r_rd_pend;
    logic                 r_vbit;

    // Candidate stage: one evaluated entry per cycle.
    logic                 r_c_pend;
    logic                 r_c_hit;
    logic [DATA_W-1:0]    r_c_src;
    logic [DATA_W-1:0]    r_c_dst;
    logic [DATA_W-1:0]    r_c_off;

    // Best match so far within the current stage.
    logic                 r_found;
    logic [DATA_W-1:0]    r_best_src;
    logic [DATA_W-1:0]    r_best_dst;
    logic [DATA_W-1:0]    r_best_off;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_value;
    logic [HITS_W-1:0]    r_out_hits;

    logic                 in_acc;
    logic                 wr_ok;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 issue;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [DATA_W-1:0]    e_dst;
    logic [DATA_W-1:0]    e_src;
    logic [DATA_W-1:0]    e_len;
    logic [DATA_W-1:0]    e_diff;
    logic                 e_match;
    logic                 take;
    logic [STCNT_W-1:0]   n_eff;
    logic                 stage_end;
    logic                 out_load;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    // Writes beyond the table are dropped.
    assign wr_ok = (32'(i_stage) < STAGES) && (32'(i_slot) < ENTRIES);
    assign wr_addr = ADDR_W'(32'(i_stage) * ENTRIES + 32'(i_slot));

    assign issue    = (r_state == S_SCAN) && (32'(r_slot) < ENTRIES);
    assign ram_we   = in_acc && (t_op'(i_operation) == OP_WRITE) && wr_ok;
    assign ram_addr = issue ? r_addr : wr_addr;

    crr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (issue),
        .i_addr  (ram_addr),
        .i_wdata ({i_dst_start, i_src_start, i_length}),
        .o_rdata (ram_rdata)
    );

    assign e_dst = ram_rdata[3*DATA_W-1:2*DATA_W];
    assign e_src = ram_rdata[2*DATA_W-1:DATA_W];
    assign e_len = ram_rdata[DATA_W-1:0];

    // An entry matches when src <= v and v - src < len, which also means a
    // zero length never matches.
    assign e_diff  = r_value - e_src;
    assign e_match = r_vbit && (r_value >= e_src) && (e_diff < e_len);

    // Slots arrive in ascending order, so a strict compare keeps the lowest
    // slot on equal source starts.
    assign take = r_c_pend && r_c_hit && (!r_found || (r_c_src < r_best_src));

    assign n_eff = (32'(r_cfg) > STAGES) ? STCNT_W'(STAGES) : STCNT_W'(r_cfg);

    assign stage_end = (r_state == S_SCAN) && (32'(r_slot) == ENTRIES + 2);

    // A finished translate moves into the output register once it is free.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg         <= CFG_W'(8);
            r_entry_valid <= '0;
            r_rd_pend     <= 1'b0;
            r_c_pend      <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_addr        <= '0;
            r_slot        <= '0;
            r_stage_cnt   <= '0;
            r_n           <= '0;
            r_hits        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_pend <= issue;
            r_vbit    <= r_entry_valid[r_addr];
            r_c_pend  <= r_rd_pend;
            r_c_hit   <= e_match;
            r_c_src   <= e_src;
            r_c_dst   <= e_dst;
            r_c_off   <= e_diff;

            if (take) begin
                r_found    <= 1'b1;
                r_best_src <= r_c_src;
                r_best_dst <= r_c_dst;
                r_best_off <= r_c_off;
            end

            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (t_op'(i_operation))
                            OP_TRANSLATE: begin
                                r_value     <= i_value;
                                r_hits      <= '0;
                                r_addr      <= '0;
                                r_slot      <= '0;
                                r_stage_cnt <= '0;
                                r_n         <= n_eff;
                                r_found     <= 1'b0;
                                r_state     <= (n_eff == '0) ? S_DONE : S_SCAN;
                            end
                            OP_WRITE: begin
                                if (wr_ok) begin
                                    r_entry_valid[wr_addr] <= 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_entry_valid <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (stage_end) begin
                        if (r_found) begin
                            r_value <= r_best_dst + r_best_off;
                            if (r_hits != HITS_MAX) begin
                                r_hits <= r_hits + 1'b1;
                            end
                        end
                        r_found     <= 1'b0;
                        r_slot      <= '0;
                        r_stage_cnt <= r_stage_cnt + 1'b1;
                        if (r_stage_cnt + 1'b1 == r_n) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_DONE: begin
                    // Wait for the output register to be free.
                    if (out_load) begin
                        r_out_value <= r_value;
                        r_out_hits  <= r_hits;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_value = r_out_value;
    assign o_stages_hit   = r_out_hits;

endmodule

@@ rtl/crr_checker.sv @@
// Port-level assertions for the cascaded range remap unit, bound to the top level.
// Depends on crr_pkg.
`timescale 1ns / 1ps

module crr_checker
    import crr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [OP_W-1:0]    i_operation,
    input logic               o_valid,
    input logic               i_ready,
    input logic [DATA_W-1:0]  o_mapped_value,
    input logic [HITS_W-1:0]  o_stages_hit
);

    // No result is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    // A waiting result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_mapped_value)
                                   && $stable(o_stages_hit)))
        else $error("waiting result changed");

    // A translate item closes the input side once it is accepted.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_operation == OP_TRANSLATE)) |=> !o_ready)
        else $error("input taken during a translate");

    // The hit count never exceeds the number of stages.
    a_hits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_stages_hit) <= STAGES))
        else $error("hit count out of range");

endmodule

bind cascaded_range_remap_unit crr_checker u_crr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_operation    (i_operation),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_mapped_value (o_mapped_value),
    .o_stages_hit   (o_stages_hit)
);

@@ bench/cascaded_range_remap_unit_tb.sv @@
// Self-checking testbench for the cascaded range remap unit: a directed table,
// then random items in several stage-count settings. Depends on crr_pkg and the RTL.
`timescale 1ns / 1ps

module cascaded_range_remap_unit_tb;
    import crr_pkg::*;

    // One input item as the sender presents it.
    typedef struct {
        t_op               op;
        logic [STAGE_W-1:0] stage;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  dst;
        logic [DATA_W-1:0]  src;
        logic [DATA_W-1:0]  len;
        logic [DATA_W-1:0]  value;
        bit                 typed;     // the expected result below is typed in
        logic [DATA_W-1:0]  t_value;
        logic [HITS_W-1:0]  t_hits;
    } t_remap_item;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [HITS_W-1:0] hits;
    } t_remap_result;

    localparam logic [DATA_W-1:0] ALL1 = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_operation;
    logic [STAGE_W-1:0]  i_stage;
    logic [SLOT_W-1:0]   i_slot;
    logic [DATA_W-1:0]   i_dst_start;
    logic [DATA_W-1:0]   i_src_start;
    logic [DATA_W-1:0]   i_length;
    logic [DATA_W-1:0]   i_value;
    logic                o_valid;
    logic                i_ready;
    logic [DATA_W-1:0]   o_mapped_value;
    logic [HITS_W-1:0]   o_stages_hit;

    cascaded_range_remap_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_stage        (i_stage),
        .i_slot         (i_slot),
        .i_dst_start    (i_dst_start),
        .i_src_start    (i_src_start),
        .i_length       (i_length),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mapped_value (o_mapped_value),
        .o_stages_hit   (o_stages_hit)
    );

    // The bench keeps its own copy of the remap tables and the register.
    logic [DATA_W-1:0] tbl_dst [TOTAL];
    logic [DATA_W-1:0] tbl_src [TOTAL];
    logic [DATA_W-1:0] tbl_len [TOTAL];
    bit                tbl_vld [TOTAL];
    logic [CFG_W-1:0]  stages_cfg;

    // Results still owed by the block, oldest first.
    t_remap_result pending_maps [$];

    int unsigned errors = 0;
    int unsigned n_translate = 0;
    int unsigned n_write = 0;
    int unsigned n_clear = 0;
    int unsigned n_checked = 0;
    int unsigned n_settings = 1;
    int unsigned burst_left = 0;
    int unsigned cyc = 0;

    // 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run; the slowest correct run is well below this.
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Pass a value through the stages in use. In each stage the matching entry
    // with the lowest source start wins; scanning slots upward and replacing only
    // on a strictly lower start gives the lowest slot on a tie.
    function automatic t_remap_result remap_value(input logic [DATA_W-1:0] v_in);
        t_remap_result     r;
        logic [DATA_W-1:0] v;
        int                n;
        int                idx;
        int                best;
        bit                found;
        int unsigned       hits;
        v = v_in;
        hits = 0;
        n = (stages_cfg > STAGES) ? STAGES : int'(stages_cfg);
        for (int s = 0; s < n; s++) begin
            found = 0;
            best = 0;
            for (int k = 0; k < ENTRIES; k++) begin
                idx = s * ENTRIES + k;
                if (tbl_vld[idx] && v >= tbl_src[idx] && (v - tbl_src[idx]) < tbl_len[idx])
                begin
                    if (!found || tbl_src[idx] < tbl_src[best]) begin
                        found = 1;
                        best = idx;
                    end
                end
            end
            if (found) begin
                v = tbl_dst[best] + (v - tbl_src[best]);
                hits++;
            end
        end
        r.value = v;
        r.hits = (hits > 15) ? 4'd15 : hits[HITS_W-1:0];
        return r;
    endfunction

    // Update the bench tables for an accepted item and queue its result.
    function automatic void absorb_item(input t_remap_item it);
        t_remap_result r;
        int            idx;
        case (it.op)
            OP_WRITE: begin
                idx = int'(it.stage) * ENTRIES + int'(it.slot);
                tbl_dst[idx] = it.dst;
                tbl_src[idx] = it.src;
                tbl_len[idx] = it.len;
                tbl_vld[idx] = 1;
                n_write++;
            end
            OP_CLEAR: begin
                foreach (tbl_vld[i]) tbl_vld[i] = 0;
                n_clear++;
            end
            OP_TRANSLATE: begin
                r = remap_value(it.value);
                if (it.typed) begin
                    r.value = it.t_value;
                    r.hits = it.t_hits;
                end
                pending_maps.push_back(r);
                n_translate++;
            end
            default: ;
        endcase
    endfunction

    // Present one item, honoring the current burst, and wait for acceptance.
    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_item(input t_remap_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            // Roughly one burst in four starts with no gap at all.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_operation <= it.op;
        i_stage     <= it.stage;
        i_slot      <= it.slot;
        i_dst_start <= it.dst;
        i_src_start <= it.src;
        i_length    <= it.len;
        i_value     <= it.value;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        absorb_item(it);
    endtask

    // Wait until every owed result has come out, then let the block settle
    // for about one full translate before anything else touches it.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_stages(input logic [CFG_W-1:0] n);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        stages_cfg = n;
        n_settings++;
    endtask

    function automatic t_remap_item mk(input t_op op, input int st, input int sl,
                                       input logic [DATA_W-1:0] dst,
                                       input logic [DATA_W-1:0] src,
                                       input logic [DATA_W-1:0] len,
                                       input logic [DATA_W-1:0] value,
                                       input bit typed,
                                       input logic [DATA_W-1:0] t_value,
                                       input int t_hits);
        t_remap_item it;
        it.op = op;
        it.stage = st[STAGE_W-1:0];
        it.slot = sl[SLOT_W-1:0];
        it.dst = dst;
        it.src = src;
        it.len = len;
        it.value = value;
        it.typed = typed;
        it.t_value = t_value;
        it.t_hits = t_hits[HITS_W-1:0];
        return it;
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Values in a small window so that ranges overlap and chain across stages.
    function automatic logic [DATA_W-1:0] near();
        return DATA_W'($urandom_range(0, 4095));
    endfunction

    // Random item. Most writes build small overlapping ranges, most translates
    // try to aim inside a live range, and a few items are clears or ignored noise.
    function automatic t_remap_item random_item();
        t_remap_item it;
        int unsigned pick;
        int          idx;
        logic [DATA_W-1:0] off;
        it = mk(OP_TRANSLATE, $urandom_range(0, 7), $urandom_range(0, 31),
                rand64(), rand64(), rand64(), rand64(), 0, '0, 0);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            it.op = OP_NONE;
        end else if (pick < 5) begin
            it.op = OP_CLEAR;
        end else if (pick < 45) begin
            it.op = OP_WRITE;
            if ($urandom_range(0, 3) != 0) begin
                it.dst = near();
                it.src = near();
                it.len = DATA_W'($urandom_range(0, 2048));
            end
        end else begin
            if ($urandom_range(0, 9) < 6) begin
                idx = $urandom_range(0, TOTAL - 1);
                if (tbl_vld[idx] && tbl_len[idx] != 0) begin
                    off = rand64() % tbl_len[idx];
                    it.value = tbl_src[idx] + off;
                end else begin
                    it.value = near();
                end
            end else if ($urandom_range(0, 1) == 0) begin
                it.value = near();
            end
        end
        return it;
    endfunction

    // Receiver: stalls according to a randomly chosen mode, and
    // once holds off for a long stretch so that the block fills and stalls.
    initial begin
        int unsigned mode;
        mode = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 500 == 0) mode = $urandom_range(0, 3);
            if (cyc >= 30000 && cyc < 33000) begin
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 1) == 0);
                    2:       i_ready <= (cyc % 4 == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Checker: every accepted result is compared with the oldest one owed.
    always @(posedge i_clk) begin
        t_remap_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_maps.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %h hits %0d",
                             o_mapped_value, o_stages_hit);
            end else begin
                want = pending_maps.pop_front();
                n_checked++;
                if (o_mapped_value !== want.value || o_stages_hit !== want.hits) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected value %h hits %0d, got value %h hits %0d",
                                 want.value, want.hits, o_mapped_value, o_stages_hit);
                end
            end
        end
    end

    // Main sequence.
    initial begin
        t_remap_item          directed [$];
        t_remap_item          it;
        logic [CFG_W-1:0]     settings [5];
        int unsigned          count;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_operation <= OP_TRANSLATE;
        i_stage     <= '0;
        i_slot      <= '0;
        i_dst_start <= '0;
        i_src_start <= '0;
        i_length    <= '0;
        i_value     <= '0;
        foreach (tbl_vld[i]) tbl_vld[i] = 0;
        stages_cfg = 4'd8;

        // Directed table. With empty tables both extremes pass unchanged.
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, ALL1, 1, ALL1, 0));
        directed.push_back(mk(OP_WRITE, 0, 0, 100, 10, 5, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 12, 1, 102, 1));
        // The range end is exclusive and the start inclusive.
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 15, 1, 15, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 10, 1, 100, 1));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 9, 1, 9, 0));
        // Same source start in a higher slot: the lower slot wins on a tie.
        directed.push_back(mk(OP_WRITE, 0, 1, 500, 10, 100, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 12, 1, 102, 1));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 50, 1, 540, 1));
        // A lower source start wins even from a higher slot.
        directed.push_back(mk(OP_WRITE, 0, 2, 900, 5, 20, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 12, 1, 907, 1));
        // A zero length never matches.
        directed.push_back(mk(OP_WRITE, 0, 3, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        // Destination sum wraps around in the second stage.
        directed.push_back(mk(OP_WRITE, 1, 31, ALL1, 0, 16, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 3, 1, 2, 1));
        // Top source start with full length: the range end must not wrap.
        directed.push_back(mk(OP_WRITE, 7, 31, 7, ALL1, ALL1, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, ALL1, 1, 7, 1));
        // Rewriting a live slot replaces the entry.
        directed.push_back(mk(OP_WRITE, 0, 2, 1000, 5, 20, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 12, 1, 1007, 1));
        // Chained hits go through the predictor.
        directed.push_back(mk(OP_WRITE, 2, 4, 40, 1000, 50, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 13, 0, 0, 0));
        // The unknown operation is ignored, then a clear empties every table.
        directed.push_back(mk(OP_NONE, 5, 9, ALL1, ALL1, ALL1, ALL1, 0, 0, 0));
        directed.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_TRANSLATE, 0, 0, 0, 0, 0, 12, 1, 12, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_item(directed[i]);

        // Random part across several stage counts, including zero stages and a
        // count above the number of stages, which acts as all of them.
        settings[0] = 4'd8;
        settings[1] = 4'd0;
        settings[2] = 4'd15;
        settings[3] = 4'd1;
        settings[4] = 4'd5;
        foreach (settings[p]) begin
            write_stages(settings[p]);
            count = 0;
            while (count < 220) begin
                it = random_item();
                send_item(it);
                if (it.op != OP_NONE) count++;
            end
        end

        wait_quiet();
        if (pending_maps.size() != 0) errors++;

        $display("Covered %0d translates, %0d writes, %0d clears over %0d stage settings.",
                 n_translate, n_write, n_clear, n_settings);
        $display("Checked %0d results, %0d failures.", n_checked, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
